// ===== src/bounded_deque_search_remove_core_macros.svh =====
// Assertion macros used by the bounded deque core.
// No dependencies; included inside module bodies after the package import.
`ifndef BOUNDED_DEQUE_SEARCH_REMOVE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_SEARCH_REMOVE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define BDSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define BDSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bdsr_pkg.sv =====
// Package for the bounded deque core: sizes, codes, transaction structs,
// controller/datapath interface structs and slot arithmetic helpers.
// No dependencies.
package bdsr_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int FIELD_W     = 5;
	localparam int IN_VAL_W    = 32;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_REMOVE     = 3'd4,
		ACT_SEARCH     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	typedef struct packed {
		action_t                     action;
		logic signed [IN_VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [FIELD_W-1:0]   position;
		logic [FIELD_W-1:0]   entry_count;
	} res_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic simple;         // execute push/pop/empty/ignored request at once
		logic load;           // latch key and start a scan
		logic scan;           // advance the scan read pipeline
		logic shift_init;     // set up tail move after a remove hit
		logic shift;          // advance the tail move pipeline
		logic reply_found;    // answer a search hit
		logic reply_miss;     // answer not found
		logic reply_removed;  // answer a completed remove
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic is_remove;
		logic hit;
		logic scan_end;
		logic shift_end;
	} dp_sts_t;

	// Store slot of the entry at a given offset from the front
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
			input logic [CNT_W-1:0] ofs);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(front) + (CNT_W+1)'(ofs);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	// Slot just ahead of the front, wrapping around the store
	function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] front);
		logic [IDX_W-1:0] prev;
		if (front == '0) begin
			prev = IDX_W'(CAPACITY - 1);
		end else begin
			prev = front - IDX_W'(1);
		end
		return prev;
	endfunction

	// Sign-extend or truncate the request value to the stored width
	function automatic logic [VALUE_WIDTH-1:0] to_entry(input logic signed [IN_VAL_W-1:0] v);
		return VALUE_WIDTH'(v);
	endfunction

endpackage

// ===== src/bdsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bdsr_ctrl.sv =====
// Controller state machine of the bounded deque core.
// Depends on bdsr_pkg; drives datapath commands from datapath status.
module bdsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bdsr_pkg::action_t action,
	input  bdsr_pkg::dp_sts_t sts,
	output bdsr_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import bdsr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   go_scan;

	// Search and remove on a non-empty store need a walk; all else is immediate
	assign go_scan = start && ((action == ACT_SEARCH) || (action == ACT_REMOVE)) && !sts.empty;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (go_scan) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (sts.hit) begin
					state_d = sts.is_remove ? S_SHIFT : S_IDLE;
				end else if (sts.scan_end) begin
					state_d = S_IDLE;
				end else begin
					state_d = state_q;
				end
			end
			S_SHIFT: begin
				if (sts.shift_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy       = 1'b0;
				cmd.load   = go_scan;
				cmd.simple = start && !go_scan;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (sts.hit) begin
					cmd.shift_init  = sts.is_remove;
					cmd.reply_found = !sts.is_remove;
				end else if (sts.scan_end) begin
					cmd.reply_miss = 1'b1;
				end else begin
					cmd.reply_miss = 1'b0;
				end
			end
			S_SHIFT: begin
				cmd.shift         = 1'b1;
				cmd.reply_removed = sts.shift_end;
			end
			default: busy = 1'b0;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/bdsr_dp.sv =====
// Datapath of the bounded deque core: front/count registers, entry store,
// scan and tail-move pipelines, result register.
// Depends on bdsr_pkg, bdsr_ram and the core macro header.
module bdsr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bdsr_pkg::req_t    req,
	input  bdsr_pkg::dp_cmd_t cmd,
	output bdsr_pkg::dp_sts_t sts,
	output logic              done,
	output bdsr_pkg::res_t    result
);
	import bdsr_pkg::*;
	`include "bounded_deque_search_remove_core_macros.svh"

	logic [IDX_W-1:0]       front_q;
	logic [IDX_W-1:0]       front_d;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic [VALUE_WIDTH-1:0] key_q;
	logic                   is_remove_q;
	logic [CNT_W-1:0]       scan_ofs_q;
	logic                   cmp_vld_q;
	logic [CNT_W-1:0]       cmp_ofs_q;
	logic [CNT_W-1:0]       sh_rd_q;
	logic [CNT_W-1:0]       sh_wr_q;
	logic                   wr_vld_q;
	logic                   done_q;
	logic                   done_d;
	res_t                   res_q;
	res_t                   res_d;

	logic                   full;
	logic                   scan_issue;
	logic                   shift_issue;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [IDX_W-1:0]       ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	assign full        = (count_q == CNT_W'(CAPACITY));
	assign scan_issue  = (scan_ofs_q < count_q);
	assign shift_issue = (sh_rd_q < count_q);

	// Status toward the controller
	assign sts.empty     = (count_q == '0);
	assign sts.is_remove = is_remove_q;
	assign sts.hit       = cmp_vld_q && (ram_rdata == key_q);
	assign sts.scan_end  = cmp_vld_q && (cmp_ofs_q == count_q - CNT_W'(1));
	assign sts.shift_end = !shift_issue && !wr_vld_q;

	// Read address: tail move source while shifting, scan offset otherwise
	assign ram_raddr = slot_of(front_q, cmd.shift ? sh_rd_q : scan_ofs_q);

	bdsr_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Request execution, store writes and result formation
	always_comb begin
		front_d         = front_q;
		count_d         = count_q;
		done_d          = 1'b0;
		res_d           = res_q;
		ram_we          = 1'b0;
		ram_waddr       = slot_of(front_q, count_q);
		ram_wdata       = to_entry(req.value);
		priority if (cmd.simple) begin
			done_d         = 1'b1;
			res_d.status   = STS_OK;
			res_d.position = '0;
			unique case (req.action)
				ACT_PUSH_FRONT: begin
					if (full) begin
						res_d.status = STS_FULL;
					end else begin
						front_d   = slot_before(front_q);
						ram_we    = 1'b1;
						ram_waddr = slot_before(front_q);
						count_d   = count_q + CNT_W'(1);
					end
				end
				ACT_PUSH_BACK: begin
					if (full) begin
						res_d.status = STS_FULL;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				ACT_POP_FRONT: begin
					if (sts.empty) begin
						res_d.status = STS_EMPTY;
					end else begin
						front_d = slot_of(front_q, CNT_W'(1));
						count_d = count_q - CNT_W'(1);
					end
				end
				ACT_POP_BACK: begin
					if (sts.empty) begin
						res_d.status = STS_EMPTY;
					end else begin
						count_d = count_q - CNT_W'(1);
					end
				end
				ACT_REMOVE, ACT_SEARCH: begin
					res_d.status = STS_EMPTY;
				end
				default: ;
			endcase
			res_d.entry_count = FIELD_W'(count_d);
		end else if (cmd.reply_found) begin
			done_d            = 1'b1;
			res_d.status      = STS_OK;
			res_d.position    = FIELD_W'(cmp_ofs_q + CNT_W'(1));
			res_d.entry_count = FIELD_W'(count_q);
		end else if (cmd.reply_miss) begin
			done_d            = 1'b1;
			res_d.status      = STS_NOT_FOUND;
			res_d.position    = '0;
			res_d.entry_count = FIELD_W'(count_q);
		end else if (cmd.reply_removed) begin
			done_d            = 1'b1;
			count_d           = count_q - CNT_W'(1);
			res_d.status      = STS_OK;
			res_d.position    = '0;
			res_d.entry_count = FIELD_W'(count_d);
		end else begin
			done_d = 1'b0;
		end
		// Move each later entry one slot toward the front
		if (cmd.shift && wr_vld_q) begin
			ram_we    = 1'b1;
			ram_waddr = slot_of(front_q, sh_wr_q);
			ram_wdata = ram_rdata;
		end
	end

	// Hold deque control state and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
			cmp_vld_q <= 1'b0;
			wr_vld_q  <= 1'b0;
		end else begin
			front_q <= front_d;
			count_q <= count_d;
			done_q  <= done_d;
			// Clear the compare on load; drop it once a match ends the walk or the entries run out
			priority if (cmd.load) begin
				cmp_vld_q <= 1'b0;
			end else if (cmd.scan) begin
				cmp_vld_q <= scan_issue && !sts.hit;
			end else begin
				cmp_vld_q <= cmp_vld_q;
			end
			priority if (cmd.shift_init) begin
				wr_vld_q <= 1'b0;
			end else if (cmd.shift) begin
				wr_vld_q <= shift_issue;
			end else begin
				wr_vld_q <= wr_vld_q;
			end
		end
	end

	// Advance scan and tail-move offsets, latch key and result
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (cmd.load) begin
			key_q       <= to_entry(req.value);
			is_remove_q <= (req.action == ACT_REMOVE);
			scan_ofs_q  <= '0;
		end else if (cmd.scan) begin
			if (scan_issue) begin
				scan_ofs_q <= scan_ofs_q + CNT_W'(1);
			end
			cmp_ofs_q <= scan_ofs_q;
		end
		priority if (cmd.shift_init) begin
			sh_rd_q <= cmp_ofs_q + CNT_W'(1);
			sh_wr_q <= cmp_ofs_q;
		end else if (cmd.shift) begin
			if (shift_issue) begin
				sh_rd_q <= sh_rd_q + CNT_W'(1);
			end
			if (wr_vld_q) begin
				sh_wr_q <= sh_wr_q + CNT_W'(1);
			end
		end else begin
			sh_rd_q <= sh_rd_q;
			sh_wr_q <= sh_wr_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`BDSR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`BDSR_ASSERT_NOW(a_hit_in_range, sts.hit, cmp_ofs_q < count_q, "match beyond held entries")
	`BDSR_ASSERT_NEXT(a_remove_drops_one, cmd.reply_removed, count_q == $past(count_q) - CNT_W'(1), "remove did not drop exactly one entry")
	`BDSR_ASSERT_NOW(a_empty_reports_zero, done_q && (res_q.status == STS_EMPTY), res_q.entry_count == '0, "empty status with nonzero count")

endmodule

// ===== src/bounded_deque_search_remove_core.sv =====
// Bounded deque of signed values with search and order-keeping removal.
// Push and pop requests answer in the cycle after acceptance and busy stays low,
// so one such request can be accepted every cycle. Search and remove walk the
// entries from the front through the registered read port of the entry
// store, one entry per cycle: a search answers once the entry at the match
// offset has been compared, or after the last entry on a miss. A remove
// additionally moves every later entry one slot toward the front, one entry
// per cycle behind the same read latency, before it answers.
// busy is high during the walk. done is high for exactly one
// cycle with result valid; it cannot be held off, so the receiver must
// capture it in that cycle. A push into a full store answers status full.
// Depends on bdsr_pkg, bdsr_ctrl and bdsr_dp.
module bounded_deque_search_remove_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bdsr_pkg::req_t req,
	output logic           done,
	output bdsr_pkg::res_t result
);
	import bdsr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequence the request
	bdsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (req.action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold entries and form the result
	bdsr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule
